// ===== rtl/pcgrnd_pkg.sv =====
package pcgrnd_pkg;

    localparam int unsigned STATE_W = 64;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned INT_W   = 31;
    localparam int unsigned CNT_W   = 6;

    localparam logic [STATE_W-1:0] LCG_MUL = 64'd6364136223846793005;
    localparam logic [STATE_W-1:0] LCG_INC = 64'd12345;

    // Last bit position of the serial multiply; the divide uses the first WORD_W steps
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STATE_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } fsm_t;

    // XSH RR output permutation of a 64-bit state
    function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] mix;
        logic [WORD_W-1:0]  x;
        logic [4:0]         rot;
        logic [2*WORD_W-1:0] dbl;
        mix = (s >> 18) ^ s;
        x   = mix[WORD_W+26:27];
        rot = s[63:59];
        dbl = {x, x} >> rot;
        return dbl[WORD_W-1:0];
    endfunction

endpackage

// ===== rtl/pcg32_basic_rnd_unit.sv =====
// Random-number unit for a BASIC-style RND call, PCG32 (LCG advance, XSH RR output).
//
// Channels: request n (signed 32 bits) on in_valid/in_ready; result fraction
// (unsigned 0.32) and int_value (1..n) on out_valid/out_ready. The user writes
// the mode register via cfg_we/cfg_wdata while the unit is idle; not enforced.
//
// For a request that advances the generator, the accepting edge loads the
// working registers, then a bit-serial shift-add multiply by the LCG constant
// (one multiplier bit per cycle) runs in ST_RUN, and ST_FIN loads the output
// register, which raises out_valid. The integer modulo runs as a restoring
// divide, one quotient bit per cycle, during the first half of those multiply
// steps. Requests that do not advance (float n = 0, integer n <= 0) go from the
// accepting edge straight to ST_FIN. One request is in work at a time, so a new
// request is accepted only once the previous one has left ST_FIN and the unit is
// back in ST_IDLE.
//
// Reset clears the generator state to zero, selects float mode and empties the
// output register. When the receiver stalls the result waits in the output
// register; the next request is still accepted and computed, then holds in its
// final step until the output register frees.
module pcg32_basic_rnd_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [pcgrnd_pkg::WORD_W-1:0] n,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pcgrnd_pkg::WORD_W-1:0] fraction,
    output logic [pcgrnd_pkg::INT_W-1:0]  int_value
);
    import pcgrnd_pkg::*;

    // Control state
    fsm_t                fsm_reg, fsm_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                mode_reg;
    logic [STATE_W-1:0]  gen_reg;
    logic                out_valid_reg;

    // Working registers of the current transaction
    logic                is_float_reg;
    logic                advance_reg;
    logic                one_reg;
    logic [STATE_W-1:0]  acc_reg;
    logic [STATE_W-1:0]  mcand_reg;
    logic [WORD_W-1:0]   r_reg;
    logic [WORD_W-1:0]   rem_reg;
    logic [INT_W-1:0]    divisor_reg;
    logic [WORD_W-1:0]   frac_reg;
    logic [INT_W-1:0]    ival_reg;

    logic                accept;
    logic                finish;
    logic                neg;
    logic                zero;
    logic [STATE_W-1:0]  seed;
    logic [WORD_W-1:0]   rand_word;
    logic [WORD_W:0]     rem_shift;
    logic [WORD_W:0]     rem_diff;
    logic [WORD_W-1:0]   rem_plus;

    assign neg  = n[WORD_W-1];
    assign zero = (n == '0);

    // Float mode with negative n seeds with the magnitude, computed at 64 bits
    assign seed      = (mode_reg && neg) ? (STATE_W'(~n) + STATE_W'(1)) : gen_reg;
    assign rand_word = xsh_rr(seed);

    // Restoring divide step: bring down the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, r_reg[WORD_W-1]};
    assign rem_diff  = rem_shift - {2'b00, divisor_reg};
    assign rem_plus  = rem_reg + WORD_W'(1);

    // Next-state logic
    always_comb
    begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if ((mode_reg && zero) || (!mode_reg && (neg || zero)))
                        fsm_next = ST_FIN;
                    else
                        fsm_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg == CNT_LAST)
                    fsm_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                    fsm_next = ST_IDLE;
            end
            default: fsm_next = ST_IDLE;
        endcase
    end

    // Output and strobe logic
    always_comb
    begin
        in_ready = 1'b0;
        finish   = 1'b0;
        case (fsm_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_RUN:  in_ready = 1'b0;
            ST_FIN:  finish   = !out_valid_reg || out_ready;
            default: in_ready = 1'b0;
        endcase
    end

    assign accept = in_valid && in_ready;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= ST_IDLE;
            cnt_reg       <= '0;
            mode_reg      <= 1'b1;
            gen_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg <= fsm_next;
            if (cfg_we)
                mode_reg <= cfg_wdata;
            if (accept)
                cnt_reg <= '0;
            else if (fsm_reg == ST_RUN)
                cnt_reg <= cnt_reg + CNT_W'(1);
            // Commit the advanced state once the result is handed to the output
            if (finish && advance_reg)
                gen_reg <= acc_reg;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_float_reg <= mode_reg;
            advance_reg  <= !zero && (mode_reg || !neg);
            one_reg      <= !mode_reg && (neg || zero);
            acc_reg      <= LCG_INC;
            mcand_reg    <= seed;
            r_reg        <= rand_word;
            rem_reg      <= '0;
            divisor_reg  <= n[INT_W-1:0];
        end
        else if (fsm_reg == ST_RUN)
        begin
            // One bit of the LCG multiplier per cycle, low bit first
            if (LCG_MUL[cnt_reg])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg <= mcand_reg << 1;
            // Divide only in integer mode so the fraction survives in r_reg
            if (!cnt_reg[CNT_W-1] && !is_float_reg)
            begin
                r_reg <= r_reg << 1;
                if (!rem_diff[WORD_W])
                    rem_reg <= rem_diff[WORD_W-1:0];
                else
                    rem_reg <= rem_shift[WORD_W-1:0];
            end
        end

        if (finish)
        begin
            frac_reg <= is_float_reg ? r_reg : '0;
            if (is_float_reg)
                ival_reg <= '0;
            else if (one_reg)
                ival_reg <= INT_W'(1);
            else
                ival_reg <= rem_plus[INT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign fraction  = frac_reg;
    assign int_value = ival_reg;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pcgrnd_pkg::*;

    // Mode register values
    localparam bit MODE_INT   = 1'b0;
    localparam bit MODE_FLOAT = 1'b1;

    // Each side idles in about this many cycles of a hundred
    localparam int unsigned IDLE_PCT = 17;
    // Window with no idling on either side (counted in transactions)
    localparam int unsigned QUIET_LO = 1000;
    localparam int unsigned QUIET_HI = 1300;
    // One long receiver hold-off, started after this many results
    localparam int unsigned HOLD_AT    = 400;
    localparam int unsigned HOLD_LEN   = 600;
    // Cycles with no transaction on either channel before the run is declared hung
    localparam int unsigned STALL_LIMIT = 4000;
    // Drain wait at the end; the slowest requests are those that advance the generator
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned PHASE_ITEMS  = 325;

    typedef struct packed {
        logic [WORD_W-1:0] fraction;
        logic [INT_W-1:0]  int_value;
    } draw_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic                     cfg_wdata = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic signed [WORD_W-1:0] n         = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [WORD_W-1:0]        fraction;
    logic [INT_W-1:0]         int_value;

    pcg32_basic_rnd_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .n         (n),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .fraction  (fraction),
        .int_value (int_value)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the generator: 64-bit LCG state plus the mode bit.
    // ------------------------------------------------------------------
    logic [STATE_W-1:0] gen_state = '0;
    bit                 float_sel = MODE_FLOAT;

    logic [WORD_W-1:0] call_args[$];     // calls waiting to be offered
    draw_t             pending_draws[$]; // predicted draws not yet seen

    int unsigned n_queued   = 0;  // calls pushed by the sequence
    int unsigned n_offered  = 0;  // calls put on the request channel
    int unsigned n_accepted = 0;  // request transactions
    int unsigned n_draws    = 0;  // result transactions
    int unsigned n_errors   = 0;

    // XSH RR: xorshift high bits down, keep 32, rotate right by the top 5 bits
    function automatic logic [WORD_W-1:0] permute_state(input logic [STATE_W-1:0] s);
        logic [WORD_W-1:0] x;
        logic [4:0]        rot;
        x   = WORD_W'(((s >> 18) ^ s) >> 27);
        rot = s[63:59];
        return (x >> rot) | (x << ((32 - rot) & 31));
    endfunction

    // Return the output of the current state, then step the LCG
    function automatic logic [WORD_W-1:0] step_state();
        logic [WORD_W-1:0] r;
        r         = permute_state(gen_state);
        gen_state = gen_state * LCG_MUL + LCG_INC;
        return r;
    endfunction

    function automatic void predict_draw(input logic [WORD_W-1:0] arg, output draw_t d);
        logic [WORD_W-1:0] r;
        d = '0;
        if (float_sel == MODE_FLOAT) begin
            // negative argument reseeds with its magnitude (2^31 for the most negative)
            if (arg[WORD_W-1])
                gen_state = {{(STATE_W-WORD_W){1'b0}}, WORD_W'(~arg + 1'b1)};
            if (arg != '0)
                d.fraction = step_state();
            else
                d.fraction = permute_state(gen_state);
        end else begin
            if (arg[WORD_W-1] || arg == '0) begin
                d.int_value = INT_W'(1);
            end else begin
                r           = step_state();
                d.int_value = INT_W'((r % arg) + 1);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver: pop the next call when the channel is free.
    // A call stays on the bus, unchanged, until its transaction completes.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (!in_valid || n_accepted == n_offered) begin
                if (call_args.size() != 0 &&
                    ((n_offered >= QUIET_LO && n_offered < QUIET_HI) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    n        <= call_args.pop_front();
                    in_valid <= 1'b1;
                    n_offered++;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random back-pressure, one long hold-off so the
    // unit fills up and stalls its request channel.
    // ------------------------------------------------------------------
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(negedge clk)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (!hold_done && n_draws >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= (n_draws >= QUIET_LO && n_draws < QUIET_HI) ||
                         ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check result transactions against the oldest prediction,
    // then predict for any request transaction at this edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : mon
        draw_t want;
        if (rst_n && out_valid && out_ready) begin
            n_draws++;
            if (pending_draws.size() == 0) begin
                $error("unexpected result: fraction=%h int_value=%0d", fraction, int_value);
                n_errors++;
            end else begin
                want = pending_draws.pop_front();
                if (fraction !== want.fraction) begin
                    $error("fraction: expected %h, got %h", want.fraction, fraction);
                    n_errors++;
                end
                if (int_value !== want.int_value) begin
                    $error("int_value: expected %0d, got %0d", want.int_value, int_value);
                    n_errors++;
                end
            end
        end
        if (rst_n && in_valid && in_ready) begin
            predict_draw(n, want);
            pending_draws.push_back(want);
            n_accepted++;
        end
    end

    // Watchdog: count cycles with no transaction on either channel
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    task automatic add_call(input logic [WORD_W-1:0] arg);
        call_args.push_back(arg);
        n_queued++;
    endtask

    // Hold until every call is accepted and every draw has come back,
    // then give the unit a few extra cycles to settle
    task automatic wait_idle();
        while (!(n_accepted == n_queued && pending_draws.size() == 0))
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_mode(input bit mode);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        float_sel = mode;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mix of zero, negatives, small moduli, powers of two and full-range values
    function automatic logic [WORD_W-1:0] pick_arg();
        case ($urandom_range(19))
            0:       return '0;
            1, 2:    return -WORD_W'($urandom_range(1, 1000));
            3:       return {1'b1, 31'($urandom)};
            4, 5, 6, 7, 8:
                     return WORD_W'($urandom_range(1, 16));
            9, 10:   return WORD_W'($urandom_range(17, 100000));
            11, 12:  return WORD_W'(1) << $urandom_range(0, 30);
            13:      return 32'h7FFF_FFFF - WORD_W'($urandom_range(0, 15));
            default: return {1'b0, 31'($urandom)};
        endcase
    endfunction

    task automatic run_phase(input bit mode, input int unsigned count);
        wait_idle();
        write_mode(mode);
        repeat (count) add_call(pick_arg());
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Float mode: zero state, no-advance on zero, seeding from the extremes
        write_mode(MODE_FLOAT);
        add_call(32'h0000_0000);
        add_call(32'h0000_0001);
        add_call(32'h0000_0000);
        add_call(32'h7FFF_FFFF);
        add_call(32'hFFFF_FFFF);
        add_call(32'h0000_0000);
        add_call(32'h8000_0000);
        add_call(32'h0000_0005);
        add_call(32'h8000_0001);
        add_call(32'h0000_0000);

        // Integer mode: non-positive arguments, modulus 1, widest modulus
        wait_idle();
        write_mode(MODE_INT);
        add_call(32'h0000_0000);
        add_call(32'hFFFF_FFFF);
        add_call(32'h8000_0000);
        add_call(32'h0000_0001);
        add_call(32'h0000_0002);
        add_call(32'h0000_0003);
        add_call(32'h7FFF_FFFF);
        add_call(32'h4000_0000);
        add_call(32'h0000_0007);
        add_call(32'h0000_0064);
        add_call(32'h7FFF_FFFE);

        run_phase(MODE_INT,   PHASE_ITEMS);
        run_phase(MODE_FLOAT, PHASE_ITEMS);
        run_phase(MODE_INT,   PHASE_ITEMS);
        run_phase(MODE_FLOAT, PHASE_ITEMS);
        run_phase(MODE_FLOAT, PHASE_ITEMS);
        run_phase(MODE_INT,   PHASE_ITEMS);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_draws.size() != 0) begin
            $error("%0d predicted results never arrived", pending_draws.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
